// ===== rtl/core/tta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_pkg
// Shared constants for the tap tempo averager: ring size, field widths,
// register indexes and reset values.
// ----------------------------------------------------------------------------
package tta_pkg;

    localparam int TAPS     = 4;
    localparam int IDX_W    = (TAPS > 2) ? $clog2(TAPS) : 1;
    localparam int CNT_W    = $clog2(TAPS);
    localparam int TIME_W   = 32;
    localparam int TEMPO_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_AW   = 2;
    localparam int PERIOD_W = 15;

    localparam logic [CFG_AW-1:0] REG_DOUBLE_TAP = 2'd0;
    localparam logic [CFG_AW-1:0] REG_MAX_PERIOD = 2'd1;
    localparam logic [CFG_AW-1:0] REG_HOLD       = 2'd2;

    localparam logic [PERIOD_W-1:0] DOUBLE_TAP_RESET = 15'd150;
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_RESET = 15'd2000;
    localparam logic [15:0]         HOLD_RESET       = 16'd1000;

endpackage

// ===== rtl/core/tta_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_div
// Restoring divider: 16-bit dividend by a small beat count, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module tta_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [tta_pkg::TEMPO_W-1:0] dividend,
    input  logic [tta_pkg::CNT_W-1:0]   divisor,
    output logic                        done,
    output logic [tta_pkg::TEMPO_W-1:0] quotient
);

    localparam int STEP_W = $clog2(tta_pkg::TEMPO_W + 1);

    logic                        busy_reg, busy_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [tta_pkg::TEMPO_W-1:0] quo_reg, quo_next;
    logic [tta_pkg::CNT_W:0]     rem_reg, rem_next;
    logic [tta_pkg::CNT_W-1:0]   dvs_reg, dvs_next;
    logic                        done_reg, done_next;
    logic [tta_pkg::CNT_W+1:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[tta_pkg::TEMPO_W-1]};
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // shift one dividend bit into the remainder, subtract if it fits
            if (trial >= {2'b00, dvs_reg}) begin
                rem_next = (tta_pkg::CNT_W+1)'(trial - {2'b00, dvs_reg});
                quo_next = {quo_reg[tta_pkg::TEMPO_W-2:0], 1'b1};
            end else begin
                rem_next = trial[tta_pkg::CNT_W:0];
                quo_next = {quo_reg[tta_pkg::TEMPO_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(tta_pkg::TEMPO_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/tap_tempo_averager_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tap_tempo_averager_top
// Tap tempo detector: one item per millisecond tick, tap times kept in a
// small synchronous ring memory, tempo averaged over adjacent gaps.
// ----------------------------------------------------------------------------
// Sequence: a tick without a tap goes straight to the output register; a tap
//   walks the ring memory entry by entry (read, then check/write back), then
//   runs a bit-serial division when any gap counts as a beat.
// Throughput: one item at a time; the next item is taken once the result
//   is in the output register.
// Reset: synchronous active-low; ring, counters, tempo and registers go to
//   their reset values, the ring through valid bits.
// ----------------------------------------------------------------------------
module tap_tempo_averager_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [0] button_level
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // [15:0] tempo_ms
    output logic [2:0]                  m_tuser,   // [0] tap_seen [1] held_pulse
                                                   // [2] double_tap
    input  logic                        cfg_wr_en,
    input  logic [tta_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [tta_pkg::CFG_W-1:0]   cfg_wr_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RDREQ  = 3'd1;
    localparam logic [2:0] ST_RDWAIT = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam int IW = tta_pkg::IDX_W;
    localparam int TW = tta_pkg::TIME_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(tta_pkg::TAPS - 1);

    logic [2:0]                  state_reg, state_next;
    logic [tta_pkg::PERIOD_W-1:0] dbl_period_reg, max_period_reg;
    logic [15:0]                 hold_period_reg;
    logic [TW-1:0]               ms_count_reg, hold_start_reg, hold_start_next;
    logic [IW-1:0]               ring_index_reg, ring_index_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic                        last_level_reg;
    logic [tta_pkg::TEMPO_W-1:0] tempo_reg, tempo_next;
    logic [tta_pkg::TEMPO_W-1:0] sum_reg, sum_next;
    logic [tta_pkg::CNT_W-1:0]   beats_reg, beats_next;
    logic [TW-1:0]               prev_reg, prev_next;
    logic                        tap_reg, tap_next;
    logic                        held_reg, held_next;
    logic                        dbl_reg, dbl_next;

    logic                        m_valid_reg;
    logic [15:0]                 m_data_reg;
    logic [2:0]                  m_user_reg;

    // ring memory
    logic [TW-1:0]               ring_mem [tta_pkg::TAPS];
    logic [tta_pkg::TAPS-1:0]    ring_vld_reg;
    logic [TW-1:0]               rd_data_reg;
    logic                        rd_vld_reg;
    logic                        mem_we;
    logic [IW-1:0]               mem_waddr;
    logic [TW-1:0]               mem_wdata;
    logic [TW-1:0]               ring_word;

    logic                        accept, level, is_tap;
    logic [TW-1:0]               hold_ref, hold_diff;
    logic [15:0]                 gap_raw;
    logic signed [16:0]          gap, lo, hi;
    logic                        is_beat, is_dbl;
    logic                        div_start, div_done;
    logic [tta_pkg::TEMPO_W-1:0] div_quo;
    logic                        out_free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign level    = s_tdata[0];
    assign is_tap   = level && !last_level_reg;
    assign out_free = !m_valid_reg || m_tready;

    assign hold_ref  = is_tap ? ms_count_reg : hold_start_reg;
    assign hold_diff = ms_count_reg - hold_ref;

    // entries never written read as zero
    assign ring_word = rd_vld_reg ? rd_data_reg : '0;
    // low 16 bits of the difference, taken as signed
    assign gap_raw = ring_word[15:0] - prev_reg[15:0];
    assign gap = $signed({gap_raw[15], gap_raw});
    assign lo  = $signed({2'b00, dbl_period_reg});
    assign hi  = $signed({2'b00, max_period_reg});
    assign is_beat = (gap > lo) && (gap < hi);
    assign is_dbl  = !is_beat && (gap > 17'sd0) && (gap < lo);

    always_comb begin
        state_next      = state_reg;
        hold_start_next = hold_start_reg;
        ring_index_next = ring_index_reg;
        idx_next        = idx_reg;
        tempo_next      = tempo_reg;
        sum_next        = sum_reg;
        beats_next      = beats_reg;
        prev_next       = prev_reg;
        tap_next        = tap_reg;
        held_next       = held_reg;
        dbl_next        = dbl_reg;
        mem_we          = 1'b0;
        mem_waddr       = ring_index_reg;
        mem_wdata       = ms_count_reg;
        div_start       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    tap_next  = is_tap;
                    dbl_next  = 1'b0;
                    held_next = 1'b0;
                    sum_next  = '0;
                    beats_next = '0;
                    idx_next  = '0;
                    if (level) begin
                        hold_start_next = hold_ref;
                        if (hold_diff >= {16'd0, hold_period_reg}) begin
                            held_next       = 1'b1;
                            hold_start_next = ms_count_reg;
                        end
                    end else begin
                        hold_start_next = ms_count_reg;
                    end
                    if (is_tap) begin
                        mem_we          = 1'b1;
                        ring_index_next = (ring_index_reg == LAST_IDX) ? '0
                                        : ring_index_reg + 1'b1;
                        state_next      = ST_RDREQ;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_RDREQ: begin
                state_next = ST_RDWAIT;
            end
            ST_RDWAIT: begin
                if (idx_reg == '0) begin
                    prev_next  = ring_word;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RDREQ;
                end else begin
                    if (is_beat) begin
                        beats_next = beats_reg + 1'b1;
                        sum_next   = sum_reg + gap[15:0];
                        prev_next  = ring_word;
                    end else if (is_dbl) begin
                        // copy the earlier time over this entry; prev holds
                        dbl_next  = 1'b1;
                        mem_we    = 1'b1;
                        mem_waddr = idx_reg;
                        mem_wdata = prev_reg;
                    end else begin
                        prev_next = ring_word;
                    end
                    if (idx_reg == LAST_IDX) begin
                        if (beats_next != '0) begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end else begin
                            state_next = ST_FINISH;
                        end
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RDREQ;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    tempo_next = div_quo;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    tta_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (beats_next),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= ring_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end else begin
            if (mem_we) begin
                ring_vld_reg[mem_waddr] <= 1'b1;
            end
            rd_vld_reg <= ring_vld_reg[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            dbl_period_reg  <= tta_pkg::DOUBLE_TAP_RESET;
            max_period_reg  <= tta_pkg::MAX_PERIOD_RESET;
            hold_period_reg <= tta_pkg::HOLD_RESET;
            ms_count_reg    <= '0;
            hold_start_reg  <= '0;
            ring_index_reg  <= '0;
            last_level_reg  <= 1'b0;
            tempo_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            hold_start_reg <= hold_start_next;
            ring_index_reg <= ring_index_next;
            tempo_reg      <= tempo_next;
            if (accept) begin
                ms_count_reg   <= ms_count_reg + 1'b1;
                last_level_reg <= level;
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    tta_pkg::REG_DOUBLE_TAP:
                        dbl_period_reg <= cfg_wr_data[tta_pkg::PERIOD_W-1:0];
                    tta_pkg::REG_MAX_PERIOD:
                        max_period_reg <= cfg_wr_data[tta_pkg::PERIOD_W-1:0];
                    tta_pkg::REG_HOLD:
                        hold_period_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        sum_reg   <= sum_next;
        beats_reg <= beats_next;
        prev_reg  <= prev_next;
        tap_reg   <= tap_next;
        held_reg  <= held_next;
        dbl_reg   <= dbl_next;
        if (state_reg == ST_FINISH && out_free) begin
            m_data_reg <= tempo_reg;
            m_user_reg <= {dbl_reg, held_reg, tap_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tap tempo averager. Button levels go in one
// item per millisecond tick; a local tempo predictor, with its own tap ring,
// hold timer and register copy, computes each tick's tempo, tap, hold-pulse
// and double-tap flags. Results are checked in order against it over several
// register settings and sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module tb;

    localparam int SETTLE_CYCLES = 2 * tta_pkg::TAPS + 40;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASES        = 9;
    localparam int PHASE_TICKS   = 150;
    localparam int MAX_PRINTS    = 30;

    typedef struct packed {
        logic [tta_pkg::TEMPO_W-1:0] tempo;
        logic                        tap;
        logic                        held;
        logic                        dbl;
    } tick_result_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [7:0]                   s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [15:0]                  m_tdata;
    logic [2:0]                   m_tuser;
    logic                         cfg_wr_en;
    logic [tta_pkg::CFG_AW-1:0]   cfg_addr;
    logic [tta_pkg::CFG_W-1:0]    cfg_wr_data;

    // Predictor state and register copy
    logic [tta_pkg::TIME_W-1:0]   ms_now;
    logic [tta_pkg::TIME_W-1:0]   tap_times [tta_pkg::TAPS];
    int                           tap_slot;
    logic [tta_pkg::TEMPO_W-1:0]  tempo_avg;
    logic [tta_pkg::TIME_W-1:0]   hold_mark;
    logic                         prev_level;
    logic [tta_pkg::PERIOD_W-1:0] dbl_period;
    logic [tta_pkg::PERIOD_W-1:0] max_gap;
    logic [15:0]                  hold_len;

    logic                tick_q [$];
    tick_result_t        expected_ticks [$];
    int                  items_queued;
    int                  items_sent;
    int                  items_accepted;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  mismatch_count;
    int                  ticks_checked;
    int                  taps_seen;
    int                  dbl_seen;
    int                  held_seen;
    int                  quiet_cycles;

    // double tap period, max period, hold period, gap ceiling, long press ceiling
    int phase_dt    [PHASES] = '{3, 0, 8, 12, 32767, 0, 2, 6, 150};
    int phase_max   [PHASES] = '{20, 10, 8, 4, 32767, 0, 32767, 30, 2000};
    int phase_hold  [PHASES] = '{5, 1, 3, 0, 65535, 7, 12, 2, 1000};
    int phase_gap   [PHASES] = '{25, 14, 14, 16, 30, 12, 40, 36, 40};
    int phase_press [PHASES] = '{15, 6, 8, 8, 20, 20, 30, 10, 40};

    tap_tempo_averager_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic tick_result_t tempo_step(input logic level);
        tick_result_t                r;
        logic [tta_pkg::TIME_W-1:0]  now;
        logic [tta_pkg::TIME_W-1:0]  diff;
        logic signed [15:0]          g16;
        int                          gap;
        int                          lo;
        int                          hi;
        int                          beats;
        logic [tta_pkg::TEMPO_W-1:0] sum;
        r   = '0;
        now = ms_now;
        if (level && !prev_level) begin
            tap_times[tap_slot] = now;
            tap_slot = (tap_slot + 1) % tta_pkg::TAPS;
            beats = 0;
            sum   = '0;
            lo    = int'(dbl_period);
            hi    = int'(max_gap);
            // walk adjacent pairs in index order; a double-tap copy feeds the next pair
            for (int i = 1; i < tta_pkg::TAPS; i++) begin
                diff = tap_times[i] - tap_times[i-1];
                g16  = diff[15:0];
                gap  = g16;
                if (gap > lo && gap < hi) begin
                    beats++;
                    sum = sum + g16;
                end else if (gap > 0 && gap < lo) begin
                    r.dbl = 1'b1;
                    tap_times[i] = tap_times[i-1];
                end
            end
            if (beats > 0)
                tempo_avg = tta_pkg::TEMPO_W'(int'(sum) / beats);
            r.tap     = 1'b1;
            hold_mark = now;
        end
        if (level) begin
            if (now - hold_mark >= {16'd0, hold_len}) begin
                r.held    = 1'b1;
                hold_mark = now;
            end
        end else begin
            hold_mark = now;
        end
        prev_level = level;
        ms_now     = now + 1;
        r.tempo    = tempo_avg;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("MISMATCH %s: got %0d expected %0d (result %0d)",
                     what, got, want, ticks_checked);
    endtask

    task automatic write_reg(input logic [tta_pkg::CFG_AW-1:0] addr, input int value);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_addr    = addr;
        cfg_wr_data = tta_pkg::CFG_W'(value);
        case (addr)
            tta_pkg::REG_DOUBLE_TAP: dbl_period = tta_pkg::PERIOD_W'(value);
            tta_pkg::REG_MAX_PERIOD: max_gap    = tta_pkg::PERIOD_W'(value);
            tta_pkg::REG_HOLD:       hold_len   = 16'(value);
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    task automatic push_level(input logic level);
        tick_q.push_back(level);
        items_queued++;
    endtask

    // Taps with random release/press lengths, a few long presses and some noise
    task automatic queue_taps(input int n, input int gap_hi, input int press_hi);
        int start;
        int g;
        int p;
        int r;
        start = items_queued;
        while (items_queued - start < n) begin
            if ($urandom_range(9) == 0) begin
                push_level(1'($urandom_range(1)));
            end else begin
                g = $urandom_range(2, gap_hi);
                if ($urandom_range(4) == 0)
                    p = $urandom_range(1, press_hi);
                else
                    p = $urandom_range(1, g - 1);
                r = (g - p < 1) ? 1 : g - p;
                repeat (r) push_level(1'b0);
                repeat (p) push_level(1'b1);
            end
        end
    endtask

    task automatic wait_drained();
        while (items_accepted != items_queued || expected_ticks.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Present the next tick when the bus is free; hold it until taken
    always @(negedge aclk) begin : drive_ticks
        logic       next_valid;
        logic [7:0] next_data;
        next_valid = s_tvalid;
        next_data  = s_tdata;
        if (aresetn) begin
            if (!s_tvalid || items_accepted == items_sent) begin
                next_valid = 1'b0;
                if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_data  = {7'd0, tick_q.pop_front()};
                    next_valid = 1'b1;
                    items_sent++;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
        s_tvalid <= next_valid;
        s_tdata  <= next_data;
    end

    always @(posedge aclk) begin : watch_ports
        tick_result_t got;
        tick_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                items_accepted++;
                expected_ticks.push_back(tempo_step(s_tdata[0]));
            end
            if (m_tvalid && m_tready) begin
                got = '{tempo: m_tdata, tap: m_tuser[0], held: m_tuser[1],
                        dbl: m_tuser[2]};
                if (expected_ticks.size() == 0) begin
                    report_mismatch("unexpected result, tempo", 32'(got.tempo), 32'd0);
                end else begin
                    want = expected_ticks.pop_front();
                    if (got.tempo !== want.tempo)
                        report_mismatch("tempo_ms", 32'(got.tempo), 32'(want.tempo));
                    if (got.tap !== want.tap)
                        report_mismatch("tap_seen", 32'(got.tap), 32'(want.tap));
                    if (got.held !== want.held)
                        report_mismatch("held_pulse", 32'(got.held), 32'(want.held));
                    if (got.dbl !== want.dbl)
                        report_mismatch("double_tap", 32'(got.dbl), 32'(want.dbl));
                    taps_seen += int'(want.tap);
                    held_seen += int'(want.held);
                    dbl_seen  += int'(want.dbl);
                end
                ticks_checked++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake in %0d cycles", STALL_LIMIT);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = '0;
        cfg_wr_data    = '0;
        ms_now         = '0;
        tap_slot       = 0;
        tempo_avg      = '0;
        hold_mark      = '0;
        prev_level     = 1'b0;
        dbl_period     = tta_pkg::DOUBLE_TAP_RESET;
        max_gap        = tta_pkg::MAX_PERIOD_RESET;
        hold_len       = tta_pkg::HOLD_RESET;
        items_queued   = 0;
        items_sent     = 0;
        items_accepted = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        ticks_checked  = 0;
        taps_seen      = 0;
        dbl_seen       = 0;
        held_seen      = 0;
        quiet_cycles   = 0;
        for (int i = 0; i < tta_pkg::TAPS; i++)
            tap_times[i] = '0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: first taps against the zeroed ring give negative gaps,
        // quick re-taps are double taps
        push_level(1'b0);
        push_level(1'b1);
        push_level(1'b0);
        push_level(1'b1);
        push_level(1'b1);
        push_level(1'b0);
        push_level(1'b1);
        push_level(1'b0);
        push_level(1'b0);
        push_level(1'b1);
        push_level(1'b1);
        push_level(1'b1);
        push_level(1'b0);
        push_level(1'b1);
        push_level(1'b0);
        push_level(1'b1);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            write_reg(tta_pkg::REG_DOUBLE_TAP, phase_dt[ph]);
            write_reg(tta_pkg::REG_MAX_PERIOD, phase_max[ph]);
            write_reg(tta_pkg::REG_HOLD, phase_hold[ph]);
            queue_taps(PHASE_TICKS, phase_gap[ph], phase_press[ph]);
            wait_drained();
        end

        if (expected_ticks.size() != 0)
            report_mismatch("results missing at end", 32'd0, 32'(expected_ticks.size()));
        $display("checked %0d ticks over %0d register settings and four idle patterns",
                 ticks_checked, PHASES + 1);
        $display("taps %0d, double taps %0d, hold pulses %0d",
                 taps_seen, dbl_seen, held_seen);
        if (mismatch_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/tta_pkg.sv
rtl/core/tta_div.sv
rtl/core/tap_tempo_averager_top.sv
tb/sv/tb.sv
